/* rtl/bbc_pkg.sv */
// Shared constants, codes and types for the Bollinger band crossover block.
`default_nettype none
package bbc_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PRICE_W    = 24;
  localparam int FRAC_W     = 8;
  localparam int LEN_W      = 7;
  localparam int K_W        = 11;
  localparam int SLOT_W     = 6;
  localparam int SUM_W      = 31;
  localparam int SQ_W       = 55;
  localparam int RAD_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int DEV_W      = 42;
  localparam int SCL_W      = 44;
  localparam int DVD_W      = 35;
  localparam int IDX_W      = 2;
  localparam int CFG_W      = 11;
  localparam int MID_W      = 24;
  localparam int UP_W       = 27;
  localparam int LO_W       = 33;

  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_K      = 2'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd20;
  localparam logic [K_W-1:0]   K_RESET   = 11'd512;
  localparam logic [LEN_W-1:0] LEN_MIN   = 7'd2;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

  localparam logic [1:0] SIG_HOLD = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUMS,
    ST_PROD,
    ST_DIFF,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DEV,
    ST_BANDS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/bbc_sqrt.sv */
// Serial floor square root, two radicand bits per cycle.
`default_nettype none
module bbc_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bbc_pkg::RAD_W-1:0]  radicand,
  output logic                            done,
  output logic [bbc_pkg::ROOT_W-1:0]      root
);
  import bbc_pkg::*;

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [4:0]        cnt;
  logic              busy;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              fits;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'(ROOT_W - 1);
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      cnt <= cnt - 5'd1;
      if (fits) begin
        rem  <= (ROOT_W+2)'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bbc_div.sv */
// Serial restoring divider by the window length, one quotient bit per cycle.
`default_nettype none
module bbc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bbc_pkg::DVD_W-1:0] dividend,
  input  wire logic [bbc_pkg::LEN_W-1:0] divisor,
  output logic                           done,
  output logic [bbc_pkg::DVD_W-1:0]      quotient
);
  import bbc_pkg::*;

  logic [LEN_W-1:0] rem;
  logic [5:0]       cnt;
  logic             busy;
  logic [LEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      cnt      <= 6'(DVD_W - 1);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (fits) begin
        rem      <= LEN_W'(rem_sh - {1'b0, divisor});
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[LEN_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bollinger_band_crossover.sv */
// Top level: price window, band arithmetic and crossover detection.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    price
//   out      output     out_valid / out_ready  signal, bands_valid, bands
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Once the window is full, an item passes the 31-step serial square root and
// then the 35-step serial dividers on its way from accept to result.
// Items before the window fills skip the square root and the dividers.
// A new item is accepted while the previous result waits in the output register.
// Reset is synchronous and clears the window; ring contents are not cleared.
`default_nettype none
module bollinger_band_crossover (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bbc_pkg::PRICE_W-1:0] price,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       signal,
  output logic                             bands_valid,
  output logic [bbc_pkg::MID_W-1:0]        middle_band,
  output logic [bbc_pkg::UP_W-1:0]         upper_band,
  output logic [bbc_pkg::LO_W-1:0]         lower_band,
  input  wire logic                        cfg_we,
  input  wire logic [bbc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]   cfg_data
);
  import bbc_pkg::*;

  state_t state, state_next;

  logic [LEN_W-1:0]   len_cfg;
  logic [K_W-1:0]     k;
  logic [LEN_W-1:0]   len;

  logic [PRICE_W-1:0] ring [MAX_WINDOW];
  logic [PRICE_W-1:0] old;
  logic [PRICE_W-1:0] x;
  logic [SLOT_W-1:0]  slot;
  logic [LEN_W-1:0]   fill;
  logic [SUM_W-1:0]   sum;
  logic [SQ_W-1:0]    sumsq;
  logic [2*PRICE_W-1:0] x_sq;
  logic [2*PRICE_W-1:0] old_sq;
  logic               item_valid;
  logic [RAD_W-1:0]   lq;
  logic [RAD_W-1:0]   ss;
  logic [RAD_W-1:0]   v;
  logic [DEV_W-1:0]   dev;
  logic signed [SCL_W-1:0] up_s;
  logic signed [SCL_W-1:0] lo_s;
  logic signed [SCL_W-1:0] xs;
  logic signed [SCL_W-1:0] ps;
  logic [PRICE_W-1:0] prev_price;
  logic signed [SCL_W-1:0] prev_lo;
  logic signed [SCL_W-1:0] prev_up;
  logic               prev_valid;
  logic [1:0]         sig;
  logic               lo_neg;

  logic               accept;
  logic               full;
  logic [SLOT_W:0]    slot_inc;
  logic               root_start;
  logic               root_done;
  logic [ROOT_W-1:0]  root;
  logic               div_start;
  logic               mid_done, up_done, lo_done;
  logic [DVD_W-1:0]   mid_q, up_q, lo_q;
  logic [DVD_W-1:0]   up_dvd, lo_dvd;
  logic signed [SCL_W-1:0] lo_shift;
  logic [SCL_W-1:0]   lo_mag;
  logic signed [SCL_W-1:0] base;
  logic [SCL_W-1:0]   den_x;
  logic [SCL_W-1:0]   den_p;
  logic [LO_W-1:0]    lo_res;

  always_comb begin
    if (len_cfg < LEN_MIN) begin
      len = LEN_MIN;
    end else if (len_cfg > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = len_cfg;
    end
  end

  assign accept   = in_valid && in_ready;
  assign full     = fill >= len;
  assign slot_inc = {1'b0, slot} + 7'd1;

  assign base     = signed'(SCL_W'({sum, {FRAC_W{1'b0}}}));
  assign den_x    = SCL_W'({32'(x * len), {FRAC_W{1'b0}}});
  assign den_p    = SCL_W'({32'(prev_price * len), {FRAC_W{1'b0}}});
  assign up_dvd   = up_s[DVD_W+FRAC_W-1:FRAC_W];
  assign lo_shift = lo_s >>> FRAC_W;
  assign lo_mag   = lo_shift[SCL_W-1] ? SCL_W'(-lo_shift) : SCL_W'(lo_shift);
  assign lo_dvd   = lo_mag[DVD_W-1:0]
                  + (lo_shift[SCL_W-1] ? DVD_W'(len - 7'd1) : DVD_W'(0));
  assign lo_res   = lo_neg ? LO_W'(-lo_q[LO_W-1:0]) : lo_q[LO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE:  state_next = ST_SUMS;
      ST_SUMS:    state_next = ST_PROD;
      ST_PROD:    state_next = item_valid ? ST_DIFF : ST_DONE;
      ST_DIFF:    state_next = ST_ROOT_GO;
      ST_ROOT_GO: begin
        root_start = 1'b1;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (root_done) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV:     state_next = ST_BANDS;
      ST_BANDS:   state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (mid_done && up_done && lo_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old <= ring[slot];
    end
    if (state == ST_SUMS) begin
      ring[slot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg    <= LEN_RESET;
      k          <= K_RESET;
      slot       <= '0;
      fill       <= '0;
      sum        <= '0;
      sumsq      <= '0;
      prev_price <= '0;
      prev_lo    <= '0;
      prev_up    <= '0;
      prev_valid <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW) begin
        len_cfg    <= cfg_data[LEN_W-1:0];
        slot       <= '0;
        fill       <= '0;
        sum        <= '0;
        sumsq      <= '0;
        prev_price <= '0;
        prev_lo    <= '0;
        prev_up    <= '0;
        prev_valid <= 1'b0;
      end else if (cfg_index == REG_K) begin
        k <= cfg_data[K_W-1:0];
      end
    end else begin
      if (state == ST_SUMS) begin
        if (full) begin
          fill  <= len;
          sum   <= sum - SUM_W'(old) + SUM_W'(x);
          sumsq <= sumsq - SQ_W'(old_sq) + SQ_W'(x_sq);
        end else begin
          fill  <= fill + 7'd1;
          sum   <= sum + SUM_W'(x);
          sumsq <= sumsq + SQ_W'(x_sq);
        end
        slot <= (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
      end
      if (state == ST_DONE && state_next == ST_IDLE) begin
        prev_price <= x;
        prev_valid <= item_valid;
        prev_lo    <= item_valid ? lo_s : '0;
        prev_up    <= item_valid ? up_s : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= price;
    end
    case (state)
      ST_SQUARE: begin
        x_sq   <= x * x;
        old_sq <= old * old;
      end
      ST_SUMS:  item_valid <= full || (fill + 7'd1 == len);
      ST_PROD: begin
        lq <= RAD_W'(len * sumsq);
        ss <= RAD_W'(sum * sum);
      end
      ST_DIFF:  v <= (lq > ss) ? lq - ss : '0;
      ST_DEV:   dev <= k * root;
      ST_BANDS: begin
        up_s <= base + signed'(SCL_W'(dev));
        lo_s <= base - signed'(SCL_W'(dev));
        xs   <= signed'(den_x);
        ps   <= signed'(den_p);
      end
      ST_DIV_GO: begin
        lo_neg <= lo_shift[SCL_W-1];
        if (prev_valid && ps >= prev_lo && xs < lo_s) begin
          sig <= SIG_BUY;
        end else if (prev_valid && ps <= prev_up && xs > up_s) begin
          sig <= SIG_SELL;
        end else begin
          sig <= SIG_HOLD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && state_next == ST_IDLE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && state_next == ST_IDLE) begin
      bands_valid <= item_valid;
      signal      <= item_valid ? sig : SIG_HOLD;
      middle_band <= item_valid ? mid_q[MID_W-1:0] : '0;
      upper_band  <= item_valid ? up_q[UP_W-1:0] : '0;
      lower_band  <= item_valid ? lo_res : '0;
    end
  end

  bbc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (v),
    .done     (root_done),
    .root     (root)
  );

  bbc_div u_div_mid (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(sum)),
    .divisor  (len),
    .done     (mid_done),
    .quotient (mid_q)
  );

  bbc_div u_div_up (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (up_dvd),
    .divisor  (len),
    .done     (up_done),
    .quotient (up_q)
  );

  bbc_div u_div_lo (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lo_dvd),
    .divisor  (len),
    .done     (lo_done),
    .quotient (lo_q)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= len)
    else $error("fill count above window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot} < len)
    else $error("write slot outside window");

  a_hold_unfilled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bands_valid |-> signal == SIG_HOLD)
    else $error("crossover reported before window full");

  a_band_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && bands_valid |->
      signed'(lower_band) <= signed'({9'd0, middle_band})
      && upper_band >= UP_W'(middle_band))
    else $error("bands out of order");

endmodule
`default_nettype wire

/* dv/bbc_checker.sv */
// Checker: watches the price and band channels, predicts each result and compares.
`timescale 1ns / 1ps
module bbc_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [bbc_pkg::PRICE_W-1:0] price,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [1:0]                  signal,
  input  wire logic                        bands_valid,
  input  wire logic [bbc_pkg::MID_W-1:0]   middle_band,
  input  wire logic [bbc_pkg::UP_W-1:0]    upper_band,
  input  wire logic [bbc_pkg::LO_W-1:0]    lower_band,
  input  wire logic                        cfg_we,
  input  wire logic [bbc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import bbc_pkg::*;

  typedef struct packed {
    logic [1:0]       sig;
    logic             valid;
    logic [MID_W-1:0] mid;
    logic [UP_W-1:0]  up;
    logic [LO_W-1:0]  lo;
  } bands_t;

  bands_t band_q[$];

  logic [LEN_W-1:0] len_reg;
  logic [K_W-1:0]   k_reg;
  longint unsigned  ring [MAX_WINDOW];
  int               slot;
  int               fill;
  longint unsigned  win_sum;
  longint unsigned  win_sq;
  longint unsigned  last_price;
  longint           last_lo_s;
  longint           last_up_s;
  bit               last_valid;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic void clear_window();
    slot = 0;
    fill = 0;
    win_sum = 0;
    win_sq = 0;
    last_price = 0;
    last_lo_s = 0;
    last_up_s = 0;
    last_valid = 0;
  endfunction

  function automatic bands_t predict_bands(longint unsigned x);
    bands_t r;
    int len;
    longint unsigned old, a, b, v, root;
    longint dev, base, den, xs, ps, lo_s, up_s;
    r = '0;
    lo_s = 0;
    up_s = 0;
    len = len_reg;
    if (len < 2) len = 2;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    if (slot >= len) slot = 0;
    if (fill >= len) begin
      old = ring[slot];
      win_sum = win_sum - old;
      win_sq = win_sq - old * old;
      fill = len;
    end else begin
      fill++;
    end
    ring[slot] = x;
    win_sum = win_sum + x;
    win_sq = win_sq + x * x;
    slot = (slot + 1 >= len) ? 0 : slot + 1;
    r.valid = (fill == len);
    if (r.valid) begin
      a = longint'(len) * win_sq;
      b = win_sum * win_sum;
      v = (a > b) ? a - b : 0;
      root = int_sqrt(v);
      dev = longint'(longint'(k_reg) * root);
      base = longint'(win_sum << FRAC_W);
      den = longint'(len) << FRAC_W;
      xs = longint'(x) * den;
      up_s = base + dev;
      lo_s = base - dev;
      r.mid = MID_W'(win_sum / len);
      r.up = UP_W'(floor_div(up_s, den));
      r.lo = LO_W'(floor_div(lo_s, den));
      if (last_valid) begin
        ps = longint'(last_price) * den;
        if (ps >= last_lo_s && xs < lo_s) r.sig = SIG_BUY;
        else if (ps <= last_up_s && xs > up_s) r.sig = SIG_SELL;
      end
    end
    last_price = x;
    last_lo_s = lo_s;
    last_up_s = up_s;
    last_valid = r.valid;
    return r;
  endfunction

  always @(posedge clk) begin
    bands_t got, want;
    if (rst) begin
      len_reg = LEN_RESET;
      k_reg = K_RESET;
      clear_window();
      band_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW) begin
          len_reg = cfg_data[LEN_W-1:0];
          clear_window();
        end else if (cfg_index == REG_K) begin
          k_reg = cfg_data[K_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        got = '{signal, bands_valid, middle_band, upper_band, lower_band};
        if (band_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = band_q.pop_front();
          if (got.sig !== want.sig || got.valid !== want.valid || got.mid !== want.mid ||
              got.up !== want.up || got.lo !== want.lo) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: sig %0d/%0d valid %0d/%0d mid %0d/%0d up %0d/%0d lo %0d/%0d",
                       want.sig, got.sig, want.valid, got.valid, want.mid, got.mid,
                       want.up, got.up, $signed(want.lo), $signed(got.lo));
          end
        end
      end
      if (in_valid && in_ready) band_q.push_back(predict_bands(longint'(price)));
    end
    pending = band_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top: price stimulus, configuration phases and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import bbc_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [PRICE_W-1:0] price;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         signal;
  logic               bands_valid;
  logic [MID_W-1:0]   middle_band;
  logic [UP_W-1:0]    upper_band;
  logic [LO_W-1:0]    lower_band;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;
  bit                 calm;
  bit                 hold_req;
  bit                 held;
  int                 quiet_cycles;
  longint             walk;

  bollinger_band_crossover uut (.*);

  bbc_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        out_ready <= 0;
        repeat (400) @(negedge clk);
        held = 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_price(logic [PRICE_W-1:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1;
    price <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [PRICE_W-1:0] next_price();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) walk = 0;
    else if (pick < 6) walk = 24'hFFFFFF;
    else if (pick < 11) walk = $urandom_range(0, 24'hFFFFFF);
    else if (pick < 20) walk = walk + $signed($urandom_range(0, 400000)) - 200000;
    else walk = walk + $signed($urandom_range(0, 4000)) - 2000;
    if (walk < 0) walk = 0;
    if (walk > 24'hFFFFFF) walk = 24'hFFFFFF;
    return PRICE_W'(walk);
  endfunction

  task automatic run_phase(logic [CFG_W-1:0] len_val, logic [CFG_W-1:0] k_val, int count);
    settle();
    write_reg(REG_WINDOW, len_val);
    write_reg(REG_K, k_val);
    walk = $urandom_range(0, 24'hFFFFFF);
    for (int i = 0; i < count; i++) send_price(next_price());
  endtask

  initial begin
    logic [PRICE_W-1:0] lead [$];
    rst = 1;
    in_valid = 0;
    price = 0;
    cfg_we = 0;
    cfg_index = REG_WINDOW;
    cfg_data = 0;
    calm = 0;
    hold_req = 0;
    walk = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(REG_WINDOW, 11'd4);
    write_reg(REG_K, 11'd1);
    lead = '{100, 100, 100, 100, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF, 5, 5};
    foreach (lead[i]) send_price(lead[i]);
    settle();
    write_reg(REG_K, 11'd0);
    lead = '{7, 7, 9, 1, 24'hFFFFFF, 0};
    foreach (lead[i]) send_price(lead[i]);
    settle();
    write_reg(REG_WINDOW, 11'h782);
    write_reg(REG_K, 11'd2047);
    lead = '{24'hFFFFFF, 0, 24'hFFFFFF, 0, 24'hAAAAAA, 24'h555555};
    foreach (lead[i]) send_price(lead[i]);

    run_phase(11'd20, 11'd512, 100);
    run_phase(11'd2, 11'd1, 100);
    run_phase(11'd64, 11'd2047, 150);
    run_phase(11'd0, 11'd256, 20);
    hold_req = 1;
    for (int i = 0; i < 80; i++) send_price(next_price());
    settle();
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'h5A5);
    run_phase(11'd1, 11'd0, 80);
    run_phase(11'd127, 11'd900, 130);
    run_phase(11'd65, 11'd64, 100);
    for (int p = 0; p < 4; p++)
      run_phase(CFG_W'($urandom_range(2, 24)), CFG_W'($urandom_range(1, 2047)), 90);
    calm = 1;
    run_phase(11'd5, 11'd300, 100);

    settle();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
